@@ rtl/core/sfe_pkg.sv @@
// Shared types and constants for the sensor frame encoder.
// Holds the channel payload structs, the front-to-back command format and the codes.
// No dependencies.
package sfe_pkg;

    localparam logic [1:0] OP_HEADER = 2'd0;
    localparam logic [1:0] OP_TEMP   = 2'd1;
    localparam logic [1:0] OP_PRES   = 2'd2;

    localparam logic [1:0] CFG_VERSION  = 2'd0;
    localparam logic [1:0] CFG_IDENTITY = 2'd1;
    localparam logic [1:0] CFG_MODE     = 2'd2;

    localparam logic [7:0]  SYNC_0    = 8'hA5;
    localparam logic [7:0]  SYNC_1    = 8'h5A;
    localparam logic [7:0]  LEN_12    = 8'd80;   // 20 + 5 * 12
    localparam logic [7:0]  LEN_32    = 8'd180;  // 20 + 5 * 32
    localparam logic [5:0]  CHANS_12  = 6'd12;
    localparam logic [5:0]  CHANS_32  = 6'd32;
    localparam logic [31:0] MASK_12   = 32'h0000_0FFF;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam int          HDR_BYTES = 18;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_CONFIG = 2'd1,
        ERR_ORDER  = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TEMP = 2'd1,
        PH_PRES = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        CMD_HDR       = 3'd0,
        CMD_TEMP      = 3'd1,
        CMD_PRES      = 3'd2,
        CMD_PRES_LAST = 3'd3,
        CMD_ERR       = 3'd4
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         status;
        logic [31:0]        sequence_req;
        logic [31:0]        sample_time;
        logic [31:0]        live_mask;
        logic signed [15:0] temperature;
        logic signed [23:0] pressure;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
        logic [1:0] error_code;
    } out_t;

    typedef struct packed {
        logic [7:0] proto_version;
        logic [7:0] identity;
        logic       channels_mode;
    } cfg_t;

    typedef struct packed {
        cmd_kind_t                    kind;
        err_t                         err;
        logic [HDR_BYTES-1:0][7:0]    bytes;
    } cmd_t;

endpackage

@@ rtl/core/sfe_front.sv @@
// Front end of the sensor frame encoder: checks order and configuration of each
// request, tracks the frame phase and builds one command for the back end.
// Depends on sfe_pkg.
module sfe_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  sfe_pkg::in_t  item,
    input  sfe_pkg::cfg_t cfg,
    output sfe_pkg::cmd_t cmd
);

    sfe_pkg::phase_t phase_reg, phase_next;
    logic [5:0]      count_reg, count_next;
    logic            mode_reg, mode_next;

    logic [5:0]  count_inc;
    logic [5:0]  frame_chans;
    logic        cfg_bad;
    logic [31:0] mask;

    assign count_inc   = 6'(count_reg + 6'd1);
    assign frame_chans = mode_reg ? sfe_pkg::CHANS_32 : sfe_pkg::CHANS_12;
    // identity bit 1 must match the mode; bit 2 must be clear for 12 channels
    assign cfg_bad     = (cfg.identity[1] != cfg.channels_mode) ||
                         (!cfg.channels_mode && cfg.identity[2]);
    assign mask        = cfg.channels_mode ? item.live_mask
                                           : (item.live_mask & sfe_pkg::MASK_12);

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        mode_next  = mode_reg;
        cmd        = '0;
        cmd.kind   = sfe_pkg::CMD_ERR;
        cmd.err    = sfe_pkg::ERR_ORDER;

        unique case (item.opcode)
            sfe_pkg::OP_HEADER:
            begin
                if (phase_reg != sfe_pkg::PH_IDLE)
                begin
                    cmd.err = sfe_pkg::ERR_ORDER;
                end
                else if (cfg_bad)
                begin
                    cmd.err = sfe_pkg::ERR_CONFIG;
                end
                else
                begin
                    cmd.kind      = sfe_pkg::CMD_HDR;
                    cmd.err       = sfe_pkg::ERR_NONE;
                    cmd.bytes[0]  = sfe_pkg::SYNC_0;
                    cmd.bytes[1]  = sfe_pkg::SYNC_1;
                    cmd.bytes[2]  = cfg.channels_mode ? sfe_pkg::LEN_32 : sfe_pkg::LEN_12;
                    cmd.bytes[3]  = cfg.proto_version;
                    cmd.bytes[4]  = cfg.identity;
                    cmd.bytes[5]  = item.status;
                    cmd.bytes[6]  = item.sequence_req[7:0];
                    cmd.bytes[7]  = item.sequence_req[15:8];
                    cmd.bytes[8]  = item.sequence_req[23:16];
                    cmd.bytes[9]  = item.sequence_req[31:24];
                    cmd.bytes[10] = item.sample_time[7:0];
                    cmd.bytes[11] = item.sample_time[15:8];
                    cmd.bytes[12] = item.sample_time[23:16];
                    cmd.bytes[13] = item.sample_time[31:24];
                    cmd.bytes[14] = mask[7:0];
                    cmd.bytes[15] = mask[15:8];
                    cmd.bytes[16] = mask[23:16];
                    cmd.bytes[17] = mask[31:24];
                    mode_next     = cfg.channels_mode;
                    phase_next    = sfe_pkg::PH_TEMP;
                    count_next    = '0;
                end
            end
            sfe_pkg::OP_TEMP:
            begin
                if (phase_reg == sfe_pkg::PH_TEMP)
                begin
                    cmd.kind     = sfe_pkg::CMD_TEMP;
                    cmd.err      = sfe_pkg::ERR_NONE;
                    cmd.bytes[0] = item.temperature[7:0];
                    cmd.bytes[1] = item.temperature[15:8];
                    if (count_inc == frame_chans)
                    begin
                        phase_next = sfe_pkg::PH_PRES;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
            end
            sfe_pkg::OP_PRES:
            begin
                if (phase_reg == sfe_pkg::PH_PRES)
                begin
                    cmd.kind     = sfe_pkg::CMD_PRES;
                    cmd.err      = sfe_pkg::ERR_NONE;
                    cmd.bytes[0] = item.pressure[7:0];
                    cmd.bytes[1] = item.pressure[15:8];
                    cmd.bytes[2] = item.pressure[23:16];
                    if (count_inc == frame_chans)
                    begin
                        // last channel: back end appends the checksum
                        cmd.kind   = sfe_pkg::CMD_PRES_LAST;
                        phase_next = sfe_pkg::PH_IDLE;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
            end
            default:
            begin
                cmd.err = sfe_pkg::ERR_ORDER;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sfe_pkg::PH_IDLE;
            count_reg <= '0;
            mode_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

@@ rtl/core/sfe_queue.sv @@
// Small first-in first-out queue between front and back end of the frame encoder.
// Generic width and depth; head entry is presented without a pop. No dependencies.
module sfe_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             empty,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_FULL);
    assign head_data = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= CNT_W'(count_reg + 1'b1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= CNT_W'(count_reg - 1'b1);
            end
        end
    end

endmodule

@@ rtl/core/sfe_back.sv @@
// Back end of the sensor frame encoder: walks the head command one byte per
// cycle while not stalled, runs the CRC-16 over frame bytes and drives the
// output register. Depends on sfe_pkg.
module sfe_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          have_cmd,
    input  sfe_pkg::cmd_t cmd,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output sfe_pkg::out_t out_data
);

    logic [4:0]     idx_reg;
    logic [15:0]    crc_reg;
    logic           valid_reg;
    sfe_pkg::out_t  data_reg;

    logic [4:0]  last_idx;
    logic        is_last;
    logic        advance;
    logic [7:0]  cur_byte;
    logic        use_crc;
    logic [15:0] crc_base;
    logic [15:0] crc_new;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ sfe_pkg::CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    always_comb
    begin
        unique case (cmd.kind)
            sfe_pkg::CMD_HDR:       last_idx = 5'(sfe_pkg::HDR_BYTES - 1);
            sfe_pkg::CMD_TEMP:      last_idx = 5'd1;
            sfe_pkg::CMD_PRES:      last_idx = 5'd2;
            sfe_pkg::CMD_PRES_LAST: last_idx = 5'd4;
            default:                last_idx = 5'd0;
        endcase
    end

    always_comb
    begin
        cur_byte = cmd.bytes[idx_reg];
        use_crc  = 1'b1;
        if (cmd.kind == sfe_pkg::CMD_ERR)
        begin
            cur_byte = '0;
            use_crc  = 1'b0;
        end
        else if (cmd.kind == sfe_pkg::CMD_PRES_LAST && idx_reg == 5'd3)
        begin
            cur_byte = crc_reg[7:0];
            use_crc  = 1'b0;
        end
        else if (cmd.kind == sfe_pkg::CMD_PRES_LAST && idx_reg == 5'd4)
        begin
            cur_byte = crc_reg[15:8];
            use_crc  = 1'b0;
        end
    end

    // restart the checksum on the first header byte
    assign crc_base = (cmd.kind == sfe_pkg::CMD_HDR && idx_reg == '0) ? sfe_pkg::CRC_INIT
                                                                       : crc_reg;
    assign crc_new  = crc_byte(crc_base, cur_byte);
    assign is_last  = (idx_reg == last_idx);
    assign advance  = have_cmd && (!valid_reg || !out_stall);
    assign pop      = advance && is_last;

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg.out_byte   <= cur_byte;
            data_reg.last_byte  <= is_last;
            data_reg.error_code <= cmd.err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            crc_reg   <= sfe_pkg::CRC_INIT;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= is_last ? '0 : 5'(idx_reg + 5'd1);
                if (use_crc)
                begin
                    crc_reg <= crc_new;
                end
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/core/sensor_frame_encoder_crc16.sv @@
// Top level of the sensor frame encoder with CRC-16/CCITT-FALSE trailer.
// Holds the configuration registers and joins sfe_front, sfe_queue and sfe_back.
// Depends on sfe_pkg.
//
// Usage:
//   Input channel (in_valid, in_stall, in_data): one request per header,
//   temperature or pressure item. in_stall rises only when the command queue
//   (QUEUE_DEPTH entries) is full.
//   Output channel (out_valid, out_stall, out_data): one frame byte per
//   transfer, last_byte marks the final byte of each request; a rejected
//   request gives a single zero byte with its error code.
//   Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data): always ready;
//   write only while no request is outstanding.
//   With the queue empty, an accepted request is queued and its first byte then
//   enters the output register, raising out_valid. The back end sends one byte
//   per cycle unless stalled; a request gives 18 (header), 2 (temperature), 3 or 5
//   (pressure) or 1 (error) bytes; a 12-channel frame is 80 bytes over 25 requests.
//   Reset: phase idle, queue empty, output invalid, configuration zero.
//   Output stall: the output register holds; the queue keeps filling and then
//   stalls the input.
module sensor_frame_encoder_crc16 #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  sfe_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output sfe_pkg::out_t out_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [7:0]    cfg_data
);

    localparam int CMD_W = $bits(sfe_pkg::cmd_t);

    sfe_pkg::cfg_t cfg_reg;
    sfe_pkg::cmd_t front_cmd;
    sfe_pkg::cmd_t head_cmd;
    logic [CMD_W-1:0] head_bits;
    logic          accept;
    logic          q_empty, q_full, q_pop;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;
    assign head_cmd  = sfe_pkg::cmd_t'(head_bits);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sfe_pkg::CFG_VERSION:  cfg_reg.proto_version <= cfg_data;
                sfe_pkg::CFG_IDENTITY: cfg_reg.identity      <= cfg_data;
                sfe_pkg::CFG_MODE:     cfg_reg.channels_mode <= cfg_data[0];
                default:               ;  // drop writes to unused indexes
            endcase
        end
    end

    sfe_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (in_data),
        .cfg    (cfg_reg),
        .cmd    (front_cmd)
    );

    sfe_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (front_cmd),
        .pop       (q_pop),
        .head_data (head_bits),
        .empty     (q_empty),
        .full      (q_full)
    );

    sfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .have_cmd  (!q_empty),
        .cmd       (head_cmd),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for sensor_frame_encoder_crc16: scripted then random requests,
// each frame byte checked against an in-bench frame encoder with its own CRC-16.
// Depends on sfe_pkg and the encoder RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_BAD = 2'd3;   // no such opcode, always rejected
    localparam int RANDOM_REQS   = 100;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 20;
    localparam int IDLE_LIMIT    = 5000;

    typedef struct packed {
        bit            is_cfg;
        logic [1:0]    idx;
        logic [7:0]    val;
        sfe_pkg::in_t  req;
        bit            typed;
        sfe_pkg::err_t code;
    } row_t;

    logic  clk;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_stall;
    sfe_pkg::in_t  in_data = '0;
    logic  out_valid;
    logic  out_stall = 1'b0;
    sfe_pkg::out_t out_data;
    logic  cfg_valid = 1'b0;
    logic  cfg_ready;
    logic  [1:0] cfg_index = '0;
    logic  [7:0] cfg_data = '0;

    // encoder shadow state
    sfe_pkg::phase_t enc_phase = sfe_pkg::PH_IDLE;
    logic [5:0]  enc_count = '0;
    logic [15:0] enc_crc = sfe_pkg::CRC_INIT;
    logic        enc_wide = 1'b0;
    logic [7:0]  reg_version = '0;
    logic [7:0]  reg_identity = '0;
    logic        reg_mode = 1'b0;

    sfe_pkg::out_t fresh[$];
    sfe_pkg::out_t wire_bytes_due[$];
    row_t script[$];

    int  errors = 0;
    int  reqs_sent = 0;
    int  bytes_checked = 0;
    int  frames_closed = 0;
    int  rejects = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;
    bit  drained = 1'b1;

    sensor_frame_encoder_crc16 DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
        c = c ^ {b, 8'h00};
        repeat (8)
        begin
            c = c[15] ? ((c << 1) ^ sfe_pkg::CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic void put_byte(logic [7:0] b, bit crc_on);
        fresh.push_back('{out_byte: b, last_byte: 1'b0, error_code: sfe_pkg::ERR_NONE});
        if (crc_on)
            enc_crc = crc_next(enc_crc, b);
    endfunction

    function automatic void put_word(logic [31:0] w);
        for (int i = 0; i < 4; i++)
            put_byte(w[8*i +: 8], 1'b1);
    endfunction

    function automatic void reject(sfe_pkg::err_t e);
        fresh.push_back('{out_byte: 8'h00, last_byte: 1'b1, error_code: e});
        rejects++;
    endfunction

    // Work out the bytes one request produces and advance the shadow state.
    function automatic void frame_encode(sfe_pkg::in_t r);
        logic [5:0]  chans;
        logic [15:0] crc_out;
        chans = enc_wide ? sfe_pkg::CHANS_32 : sfe_pkg::CHANS_12;
        fresh.delete();
        case (r.opcode)
            sfe_pkg::OP_HEADER:
            begin
                if (enc_phase != sfe_pkg::PH_IDLE)
                    reject(sfe_pkg::ERR_ORDER);
                else if (reg_identity[1] != reg_mode || (!reg_mode && reg_identity[2]))
                    reject(sfe_pkg::ERR_CONFIG);
                else
                begin
                    enc_wide = reg_mode;
                    enc_crc = sfe_pkg::CRC_INIT;
                    put_byte(sfe_pkg::SYNC_0, 1'b1);
                    put_byte(sfe_pkg::SYNC_1, 1'b1);
                    put_byte(enc_wide ? sfe_pkg::LEN_32 : sfe_pkg::LEN_12, 1'b1);
                    put_byte(reg_version, 1'b1);
                    put_byte(reg_identity, 1'b1);
                    put_byte(r.status, 1'b1);
                    put_word(r.sequence_req);
                    put_word(r.sample_time);
                    put_word(enc_wide ? r.live_mask : (r.live_mask & sfe_pkg::MASK_12));
                    enc_phase = sfe_pkg::PH_TEMP;
                    enc_count = '0;
                end
            end
            sfe_pkg::OP_TEMP:
            begin
                if (enc_phase != sfe_pkg::PH_TEMP)
                    reject(sfe_pkg::ERR_ORDER);
                else
                begin
                    put_byte(r.temperature[7:0], 1'b1);
                    put_byte(r.temperature[15:8], 1'b1);
                    enc_count = enc_count + 6'd1;
                    if (enc_count >= chans)
                    begin
                        enc_phase = sfe_pkg::PH_PRES;
                        enc_count = '0;
                    end
                end
            end
            sfe_pkg::OP_PRES:
            begin
                if (enc_phase != sfe_pkg::PH_PRES)
                    reject(sfe_pkg::ERR_ORDER);
                else
                begin
                    put_byte(r.pressure[7:0], 1'b1);
                    put_byte(r.pressure[15:8], 1'b1);
                    put_byte(r.pressure[23:16], 1'b1);
                    enc_count = enc_count + 6'd1;
                    if (enc_count >= chans)
                    begin
                        // CRC trailer is not folded into itself
                        crc_out = enc_crc;
                        put_byte(crc_out[7:0], 1'b0);
                        put_byte(crc_out[15:8], 1'b0);
                        enc_phase = sfe_pkg::PH_IDLE;
                        enc_count = '0;
                        enc_crc = sfe_pkg::CRC_INIT;
                        frames_closed++;
                    end
                end
            end
            default:
                reject(sfe_pkg::ERR_ORDER);
        endcase
        fresh[fresh.size() - 1].last_byte = 1'b1;
    endfunction

    function automatic logic [31:0] pick(int w);
        logic [31:0] ones;
        ones = (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
        case ($urandom_range(7))
            0: return 32'd0;
            1: return ones;
            2: return 32'd1 << (w - 1);
            3: return ones >> 1;
            default: return $urandom & ones;
        endcase
    endfunction

    function automatic sfe_pkg::in_t rand_req(logic [1:0] op);
        sfe_pkg::in_t r;
        r.opcode       = op;
        r.status       = 8'(pick(8));
        r.sequence_req = pick(32);
        r.sample_time  = pick(32);
        r.live_mask    = pick(32);
        r.temperature  = 16'(pick(16));
        r.pressure     = 24'(pick(24));
        return r;
    endfunction

    function automatic sfe_pkg::in_t make_req(logic [1:0] op, logic [7:0] st,
                                              logic [31:0] sq, logic [31:0] tm,
                                              logic [31:0] fm, logic [15:0] t,
                                              logic [23:0] p);
        return '{opcode: op, status: st, sequence_req: sq, sample_time: tm,
                 live_mask: fm, temperature: t, pressure: p};
    endfunction

    function automatic row_t req_row(sfe_pkg::in_t r, bit typed, sfe_pkg::err_t code);
        return '{is_cfg: 1'b0, idx: 2'd0, val: 8'd0, req: r, typed: typed, code: code};
    endfunction

    function automatic row_t cfg_row(logic [1:0] idx, logic [7:0] v);
        return '{is_cfg: 1'b1, idx: idx, val: v, req: '0, typed: 1'b0,
                 code: sfe_pkg::ERR_NONE};
    endfunction

    // Hold off new requests until every outstanding byte has come out.
    task automatic settle();
        if (!drained)
        begin
            in_valid <= 1'b0;
            while (wire_bytes_due.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
            drained = 1'b1;
        end
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [7:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            sfe_pkg::CFG_VERSION:  reg_version  = v;
            sfe_pkg::CFG_IDENTITY: reg_identity = v;
            sfe_pkg::CFG_MODE:     reg_mode     = v[0];
            default: ;
        endcase
    endtask

    task automatic send_req(sfe_pkg::in_t r, bit typed, sfe_pkg::err_t code);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 15)
            gap = $urandom_range(1, 2);
        cfg_valid <= 1'b0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        frame_encode(r);
        if (typed)
            wire_bytes_due.push_back('{out_byte: 8'h00, last_byte: 1'b1, error_code: code});
        else
            foreach (fresh[i])
                wire_bytes_due.push_back(fresh[i]);
        reqs_sent++;
        drained = 1'b0;
    endtask

    task automatic reconfigure();
        bit         wide;
        logic [7:0] idv;
        wide = ($urandom_range(3) == 0);
        idv = 8'(pick(8));
        idv[1] = wide;
        if (!wide)
            idv[2] = 1'b0;
        if ($urandom_range(4) == 0)
            idv = 8'($urandom_range(255));
        cfg_write(sfe_pkg::CFG_VERSION, 8'(pick(8)));
        cfg_write(sfe_pkg::CFG_IDENTITY, idv);
        cfg_write(sfe_pkg::CFG_MODE, {7'd0, wide});
    endtask

    task automatic flag(string what, logic [7:0] want, logic [7:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    endtask

    always @(posedge clk)
    begin
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 15);
    end

    always @(posedge clk)
    begin
        sfe_pkg::out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (wire_bytes_due.size() == 0)
                flag("unexpected byte", 8'h00, out_data.out_byte);
            else
            begin
                want = wire_bytes_due.pop_front();
                bytes_checked++;
                if (want.out_byte !== out_data.out_byte)
                    flag("out_byte", want.out_byte, out_data.out_byte);
                if (want.last_byte !== out_data.last_byte)
                    flag("last_byte", {7'd0, want.last_byte}, {7'd0, out_data.last_byte});
                if (want.error_code !== out_data.error_code)
                    flag("error_code", {6'd0, want.error_code}, {6'd0, out_data.error_code});
            end
        end
    end

    // Watchdog: end the run when no channel moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no progress, %0d bytes still due", $time, wire_bytes_due.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        sfe_pkg::in_t r;
        int  n;
        int  roll;

        // Out-of-order requests in idle and temperature phases, both bad 12-channel
        // identity settings, field extremes, then a mode change in a 12-channel frame.
        script.push_back(req_row(make_req(sfe_pkg::OP_TEMP, '0, '0, '0, '0, 16'h7FFF, '0),
                                 1'b1, sfe_pkg::ERR_ORDER));
        script.push_back(req_row(make_req(sfe_pkg::OP_PRES, '0, '0, '0, '0, '0, 24'h800000),
                                 1'b1, sfe_pkg::ERR_ORDER));
        script.push_back(req_row(make_req(OP_BAD, 8'hFF, '1, '1, '1, '1, '1),
                                 1'b1, sfe_pkg::ERR_ORDER));
        script.push_back(cfg_row(sfe_pkg::CFG_IDENTITY, 8'h02));
        script.push_back(req_row(make_req(sfe_pkg::OP_HEADER, '0, '0, '0, '0, '0, '0),
                                 1'b1, sfe_pkg::ERR_CONFIG));
        script.push_back(cfg_row(sfe_pkg::CFG_IDENTITY, 8'h04));
        script.push_back(req_row(make_req(sfe_pkg::OP_HEADER, '0, '0, '0, '0, '0, '0),
                                 1'b1, sfe_pkg::ERR_CONFIG));
        script.push_back(cfg_row(sfe_pkg::CFG_VERSION, 8'hFF));
        script.push_back(cfg_row(sfe_pkg::CFG_IDENTITY, 8'hF9));
        script.push_back(req_row(make_req(sfe_pkg::OP_HEADER, 8'hFF, 32'hFFFF_FFFF, 32'h0,
                                          32'hFFFF_FFFF, '0, '0), 1'b0, sfe_pkg::ERR_NONE));
        script.push_back(req_row(make_req(sfe_pkg::OP_HEADER, '0, '0, '0, '0, '0, '0),
                                 1'b1, sfe_pkg::ERR_ORDER));
        script.push_back(req_row(make_req(sfe_pkg::OP_PRES, '0, '0, '0, '0, '0, 24'h7FFFFF),
                                 1'b1, sfe_pkg::ERR_ORDER));
        script.push_back(req_row(make_req(OP_BAD, '0, '0, '0, '0, '0, '0),
                                 1'b1, sfe_pkg::ERR_ORDER));
        script.push_back(req_row(make_req(sfe_pkg::OP_TEMP, '0, '0, '0, '0, 16'h8000, '0),
                                 1'b0, sfe_pkg::ERR_NONE));
        script.push_back(req_row(make_req(sfe_pkg::OP_TEMP, '0, '0, '0, '0, 16'h7FFF, '0),
                                 1'b0, sfe_pkg::ERR_NONE));
        script.push_back(req_row(make_req(sfe_pkg::OP_TEMP, '0, '0, '0, '0, 16'h0000, '0),
                                 1'b0, sfe_pkg::ERR_NONE));
        script.push_back(req_row(make_req(sfe_pkg::OP_TEMP, '0, '0, '0, '0, 16'hFFFF, '0),
                                 1'b0, sfe_pkg::ERR_NONE));
        script.push_back(cfg_row(sfe_pkg::CFG_MODE, 8'h01));
        script.push_back(cfg_row(sfe_pkg::CFG_IDENTITY, 8'h02));
        script.push_back(req_row(make_req(sfe_pkg::OP_TEMP, '0, '0, '0, '0, 16'h1234, '0),
                                 1'b0, sfe_pkg::ERR_NONE));
        script.push_back(req_row(make_req(sfe_pkg::OP_HEADER, '0, '0, '0, '0, '0, '0),
                                 1'b1, sfe_pkg::ERR_ORDER));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].is_cfg)
                cfg_write(script[i].idx, script[i].val);
            else
                send_req(script[i].req, script[i].typed, script[i].code);
        end

        // Mostly well-formed frames with random content, some noise mixed in.
        n = 0;
        while (n < RANDOM_REQS || enc_phase != sfe_pkg::PH_IDLE)
        begin
            calm = (n >= 30 && n < 70);
            roll = $urandom_range(99);
            if (roll < 12)
                r = rand_req(2'($urandom_range(3)));
            else
            begin
                case (enc_phase)
                    sfe_pkg::PH_IDLE:
                    begin
                        if (reg_identity[1] != reg_mode || (!reg_mode && reg_identity[2]) ||
                            $urandom_range(3) == 0)
                            reconfigure();
                        r = rand_req(sfe_pkg::OP_HEADER);
                    end
                    sfe_pkg::PH_TEMP: r = rand_req(sfe_pkg::OP_TEMP);
                    default: r = rand_req(sfe_pkg::OP_PRES);
                endcase
            end
            if (n == 60 || $urandom_range(39) == 0)
                settle();
            send_req(r, 1'b0, sfe_pkg::ERR_NONE);
            n++;
        end

        calm = 1'b0;
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (wire_bytes_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d rejected), checked %0d bytes, closed %0d frames.",
                 reqs_sent, rejects, bytes_checked, frames_closed);
        $display("Both channel modes, bad identity settings and out-of-order requests exercised.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
